/* src/sfsd_pkg.sv */
// Shared types and constants for the sparse feature stream decoder.
// No dependencies; every other file in src imports this package.
package sfsd_pkg;

    localparam logic [31:0] VAL_NEG_ONE = 32'hBF80_0000;
    localparam logic [31:0] VAL_POS_ONE = 32'h3F80_0000;
    localparam int unsigned CODE_NEG_BIT = 0;
    localparam int unsigned CODE_GENERAL_BIT = 1;
    localparam logic [2:0] SHIFT_SAT = 3'd5;
    localparam logic [1:0] FLOAT_LAST = 2'd3;
    localparam logic [31:0] INDEX_MASK_RESET = 32'h0003_FFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       namespace_start;
    } sfsd_in_t;

    typedef struct packed {
        logic [31:0] feature_index;
        logic [31:0] value_bits;
        logic        negative_delta;
    } sfsd_out_t;

    // Feature completed by the current byte: zigzag field and value.
    typedef struct packed {
        logic        emit;
        logic [29:0] diff;
        logic [31:0] value;
    } sfsd_feat_t;

    typedef enum logic [1:0] {
        PH_VARINT = 2'b01,
        PH_FLOAT  = 2'b10
    } sfsd_phase_t;

endpackage

/* src/sparse_feature_stream_decoder_unit.sv */
// Top level of the sparse feature stream decoder: input register, decode, result register.
// Depends on sfsd_pkg, sfsd_byte_decoder and sfsd_index_accum.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | request   | in_valid / in_stall   | in_data  (byte, namespace mark)
//  out     | result    | out_valid / out_stall | out_data (index, value, flag)
//  cfg     | write     | cfg_wr_en             | cfg_wr_data (index mask)
//
// One byte per cycle sustained unless a completed feature meets a stalled result: a
// request is held in the input register, decoded in one pass and the feature, if
// any, lands in the result register on the same edge. Reset clears the decoder, the
// running index and both valid bits, and loads the index mask with 0x3FFFF.
// A stalled result holds; the input register still takes one more request, and
// bytes that complete no feature keep advancing past a full result register.
module sparse_feature_stream_decoder_unit #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sfsd_pkg::sfsd_in_t    in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sfsd_pkg::sfsd_out_t   out_data,
    input  logic                  cfg_wr_en,
    input  logic [31:0]           cfg_wr_data
);
    import sfsd_pkg::*;

    logic        in_valid_reg;
    sfsd_in_t    in_item_reg;
    logic        out_valid_reg, out_valid_next;
    sfsd_out_t   out_data_reg;
    logic [31:0] index_mask_reg;
    logic        out_free, step, load_in;
    sfsd_feat_t  feat;
    logic [31:0] feature_index;
    logic        negative_delta;

    // Result slot frees when empty or being taken this cycle.
    assign out_free = !out_valid_reg || !out_stall;
    // Advance the held request unless it completes a feature with nowhere to go.
    assign step     = in_valid_reg && (!feat.emit || out_free);
    assign in_stall = in_valid_reg && !step;
    assign load_in  = in_valid && !in_stall;

    sfsd_byte_decoder u_dec (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .in_item (in_item_reg),
        .feat    (feat)
    );

    sfsd_index_accum #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_idx (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .clear          (in_item_reg.namespace_start),
        .emit           (feat.emit),
        .diff           (feat.diff),
        .index_mask     (index_mask_reg),
        .feature_index  (feature_index),
        .negative_delta (negative_delta)
    );

    always_comb
    begin
        if (step && feat.emit)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    // Control state and the mask register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            index_mask_reg <= INDEX_MASK_RESET;
        end
        else
        begin
            if (load_in)
                in_valid_reg <= 1'b1;
            else if (step)
                in_valid_reg <= 1'b0;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                index_mask_reg <= cfg_wr_data;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (load_in)
            in_item_reg <= in_data;
        if (step && feat.emit)
        begin
            out_data_reg.feature_index  <= feature_index;
            out_data_reg.value_bits     <= feat.value;
            out_data_reg.negative_delta <= negative_delta;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* src/sfsd_byte_decoder.sv */
// Varint and float-byte decoder: turns bytes into completed features.
// Depends on sfsd_pkg.
module sfsd_byte_decoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  sfsd_pkg::sfsd_in_t in_item,
    output sfsd_pkg::sfsd_feat_t feat
);
    import sfsd_pkg::*;

    sfsd_phase_t phase_reg, phase_next, phase_cur;
    logic [31:0] accum_reg, accum_next, accum_cur, accum_add;
    logic [2:0]  shift_reg, shift_next, shift_cur;
    logic [1:0]  fcount_reg, fcount_next, fcount_cur;
    logic [29:0] pend_reg, pend_next, pend_cur;
    logic [23:0] fasm_reg, fasm_next, fasm_cur;
    logic [7:0]  b;
    logic [31:0] code;

    assign b = in_item.data_byte;

    always_comb
    begin
        // Start mark drops any partial code or float.
        phase_cur  = in_item.namespace_start ? PH_VARINT : phase_reg;
        accum_cur  = in_item.namespace_start ? '0 : accum_reg;
        shift_cur  = in_item.namespace_start ? '0 : shift_reg;
        fcount_cur = in_item.namespace_start ? '0 : fcount_reg;
        pend_cur   = in_item.namespace_start ? '0 : pend_reg;
        fasm_cur   = in_item.namespace_start ? '0 : fasm_reg;

        case (shift_cur)
            3'd0:    accum_add = {25'd0, b[6:0]};
            3'd1:    accum_add = {18'd0, b[6:0], 7'd0};
            3'd2:    accum_add = {11'd0, b[6:0], 14'd0};
            3'd3:    accum_add = {4'd0, b[6:0], 21'd0};
            3'd4:    accum_add = {b[3:0], 28'd0};
            default: accum_add = '0;
        endcase
        code = accum_cur | accum_add;

        phase_next  = phase_cur;
        accum_next  = accum_cur;
        shift_next  = shift_cur;
        fcount_next = fcount_cur;
        pend_next   = pend_cur;
        fasm_next   = fasm_cur;
        feat.emit   = 1'b0;
        feat.diff   = code[31:2];
        feat.value  = VAL_POS_ONE;

        case (phase_cur)
            PH_FLOAT:
            begin
                if (fcount_cur != FLOAT_LAST)
                begin
                    case (fcount_cur)
                        2'd0:    fasm_next = fasm_cur | {16'd0, b};
                        2'd1:    fasm_next = fasm_cur | {8'd0, b, 8'd0};
                        default: fasm_next = fasm_cur | {b, 16'd0};
                    endcase
                    fcount_next = fcount_cur + 2'd1;
                end
                else
                begin
                    feat.emit   = 1'b1;
                    feat.diff   = pend_cur;
                    feat.value  = {b, fasm_cur};
                    phase_next  = PH_VARINT;
                    fcount_next = '0;
                    pend_next   = '0;
                    fasm_next   = '0;
                end
            end
            default:
            begin
                if (b[7])
                begin
                    accum_next = code;
                    if (shift_cur != SHIFT_SAT)
                        shift_next = shift_cur + 3'd1;
                end
                else
                begin
                    accum_next = '0;
                    shift_next = '0;
                    if (code[CODE_NEG_BIT])
                    begin
                        feat.emit  = 1'b1;
                        feat.value = VAL_NEG_ONE;
                    end
                    else if (code[CODE_GENERAL_BIT])
                    begin
                        pend_next   = code[31:2];
                        phase_next  = PH_FLOAT;
                        fcount_next = '0;
                        fasm_next   = '0;
                    end
                    else
                    begin
                        feat.emit = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_VARINT;
            accum_reg  <= '0;
            shift_reg  <= '0;
            fcount_reg <= '0;
            pend_reg   <= '0;
            fasm_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            accum_reg  <= accum_next;
            shift_reg  <= shift_next;
            fcount_reg <= fcount_next;
            pend_reg   <= pend_next;
            fasm_reg   <= fasm_next;
        end
    end

endmodule

/* src/sfsd_index_accum.sv */
// Zigzag delta decode and running index accumulator with output masking.
// Depends on sfsd_pkg.
module sfsd_index_accum #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic        clear,
    input  logic        emit,
    input  logic [29:0] diff,
    input  logic [31:0] index_mask,
    output logic [31:0] feature_index,
    output logic        negative_delta
);
    import sfsd_pkg::*;

    logic [INDEX_WIDTH-1:0] run_reg, run_next, run_cur, sum;
    logic [31:0]            delta;

    always_comb
    begin
        negative_delta = diff[0];
        delta   = {3'd0, diff[29:1]} ^ {32{diff[0]}};
        run_cur = clear ? '0 : run_reg;
        sum     = run_cur + delta[INDEX_WIDTH-1:0];
        run_next = emit ? sum : run_cur;
        feature_index = 32'(sum & index_mask[INDEX_WIDTH-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_reg <= '0;
        else if (step)
            run_reg <= run_next;
    end

endmodule
